>>> rtl/ttst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_pkg
// Widths, constants and shared types of the trapezoid traffic speed tracker.
// ----------------------------------------------------------------------------
package ttst_pkg;

    localparam int TIME_W   = 63;
    localparam int BYTE_W   = 48;
    localparam int SPEED_W  = 48;
    localparam int K_W      = 31;
    // delta bytes times two seconds in ns stays below 2^79
    localparam int PROD_W   = BYTE_W + K_W;
    localparam int MUL_SPLIT = 24;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [K_W-1:0]     NS_PER_S_X2 = K_W'(2000000000);
    localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};

    // one accepted sample with its deltas, as queued for the back end
    typedef struct packed {
        logic [TIME_W-1:0] t_now;
        logic [TIME_W-1:0] t_last;
        logic [TIME_W-1:0] dt;
        logic [BYTE_W-1:0] db;
    } t_job;

    typedef struct packed {
        logic [PROD_W-1:0] quo;
        logic [TIME_W-1:0] rem;
    } t_div_res;

endpackage

>>> rtl/ttst_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_if
// Valid/ready channels for traffic samples and speed results.
// ----------------------------------------------------------------------------
interface ttst_sample_if
    import ttst_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] sample_time_ns;
    logic [BYTE_W-1:0] byte_total;

    modport source (output valid, output sample_time_ns, output byte_total, input ready);
    modport sink   (input valid, input sample_time_ns, input byte_total, output ready);
endinterface

interface ttst_speed_if
    import ttst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] speed_bps;
    logic [TIME_W-1:0]  speed_at_ns;

    modport source (output valid, output speed_bps, output speed_at_ns, input ready);
    modport sink   (input valid, input speed_bps, input speed_at_ns, output ready);
endinterface

>>> rtl/ttst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_front
// Accepts samples, drops stale or falling ones, tracks last time and total
// and forms the deltas for the back end.
// ----------------------------------------------------------------------------
module ttst_front
    import ttst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttst_sample_if.sink  i_sample,
    input  logic         i_full,
    output logic         o_push,
    output t_job         o_job
);

    logic [TIME_W-1:0] r_last_time;
    logic [BYTE_W-1:0] r_last_total;
    logic              accept;
    logic              stale;

    assign i_sample.ready = !i_full;
    assign accept = i_sample.valid && i_sample.ready;
    assign stale  = (i_sample.sample_time_ns <= r_last_time) ||
                    (i_sample.byte_total < r_last_total);
    assign o_push = accept && !stale;

    assign o_job.t_now  = i_sample.sample_time_ns;
    assign o_job.t_last = r_last_time;
    assign o_job.dt     = i_sample.sample_time_ns - r_last_time;
    assign o_job.db     = i_sample.byte_total - r_last_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_last_total <= '0;
        end else if (o_push) begin
            r_last_time  <= i_sample.sample_time_ns;
            r_last_total <= i_sample.byte_total;
        end
    end

    // a queued sample always moves time forward
    a_dt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.dt != '0))
        else $error("queued sample with zero elapsed time");

    a_state_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_last_time == $past(i_sample.sample_time_ns)))
        else $error("last time not taken from accepted sample");

    a_stale_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && stale) |=> $stable(r_last_time) && $stable(r_last_total))
        else $error("stale sample changed tracker state");

endmodule

>>> rtl/ttst_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_fifo
// Small job queue between front and back end.
// ----------------------------------------------------------------------------
module ttst_fifo
    import ttst_pkg::*;
#(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty job queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(P_DEPTH))
        else $error("job queue count out of range");

endmodule

>>> rtl/ttst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttst_div
    import ttst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [TIME_W-1:0] i_divisor,
    output logic              o_done,
    output t_div_res          o_res
);

    localparam int CNT_W = $clog2(PROD_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_quo;
    logic [TIME_W-1:0] r_rem;
    logic [TIME_W-1:0] r_div;
    logic [TIME_W:0]   trial;
    logic              take;
    logic [TIME_W:0]   trial_sub;

    // dividend bits shift out of the top of the quotient register
    assign trial     = {r_rem, r_quo[PROD_W-1]};
    assign take      = (trial >= {1'b0, r_div});
    assign trial_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], take};
            r_rem <= take ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_res.quo = r_quo;
    assign o_res.rem = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_div != '0)) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

endmodule

>>> rtl/ttst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttst_back
// Runs one queued sample: wide multiply, two divisions, speed select and
// saturation, then holds the result for the output channel.
// ----------------------------------------------------------------------------
module ttst_back
    import ttst_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  t_job          i_job,
    output logic          o_pop,
    ttst_speed_if.source  o_speed
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL0 = 6'b000010,
        S_MUL1 = 6'b000100,
        S_GO   = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_back_state;

    localparam int HI_W = BYTE_W - MUL_SPLIT;
    localparam int PP_W = HI_W + K_W;

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [PROD_W-1:0]  r_acc;
    logic [SPEED_W-1:0] r_last_speed;
    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_speed;
    logic [TIME_W-1:0]  r_out_time;

    logic [HI_W-1:0]    mul_op;
    logic [PP_W-1:0]    mul_pp;
    logic               div_go;
    logic               done_dt;
    logic               done_ps;
    t_div_res           res_dt;
    t_div_res           res_ps;
    logic               out_free;

    logic [PROD_W-1:0]  ps_ext;
    logic [PROD_W-1:0]  diff;
    logic               q_ge;
    logic               near;
    logic               sat;
    logic [SPEED_W-1:0] n_speed;
    logic [TIME_W-1:0]  n_time;

    // one 24x31 multiplier, low half then high half
    assign mul_op = (r_state == S_MUL0) ? HI_W'(r_job.db[MUL_SPLIT-1:0])
                                        : r_job.db[BYTE_W-1:MUL_SPLIT];
    assign mul_pp = mul_op * NS_PER_S_X2;

    assign div_go = (r_state == S_GO);

    ttst_div u_div_dt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_acc),
        .i_divisor  (r_job.dt),
        .o_done     (done_dt),
        .o_res      (res_dt)
    );

    // zero-crossing time, only used when the speed goes negative
    ttst_div u_div_ps (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (r_acc),
        .i_divisor  (TIME_W'(r_last_speed)),
        .o_done     (done_ps),
        .o_res      (res_ps)
    );

    assign ps_ext = PROD_W'(r_last_speed);
    assign q_ge   = (res_dt.quo >= ps_ext);
    assign diff   = res_dt.quo - ps_ext;
    assign sat    = (diff > PROD_W'(SPEED_MAX));
    // quotient just under zero truncates to zero at the new timestamp
    assign near   = (res_dt.quo == ps_ext - 1'b1) && (res_dt.rem != '0);

    always_comb begin
        if (q_ge) begin
            n_speed = sat ? SPEED_MAX : diff[SPEED_W-1:0];
            n_time  = r_job.t_now;
        end else if (near) begin
            n_speed = '0;
            n_time  = r_job.t_now;
        end else begin
            n_speed = '0;
            n_time  = r_job.t_last + res_ps.quo[TIME_W-1:0];
        end
    end

    assign out_free = !r_out_valid || o_speed.ready;
    assign o_pop    = (r_state == S_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid) n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_GO;
            S_GO:   n_state = S_DIV;
            S_DIV:  if (done_dt) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_MUL0) begin
            r_acc <= PROD_W'(mul_pp);
        end else if (r_state == S_MUL1) begin
            r_acc <= r_acc + {mul_pp, {MUL_SPLIT{1'b0}}};
        end
        if ((r_state == S_FIN) && out_free) begin
            r_out_speed <= n_speed;
            r_out_time  <= n_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_speed <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && out_free) begin
                r_last_speed <= n_speed;
                r_out_valid  <= 1'b1;
            end else if (o_speed.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_speed.valid       = r_out_valid;
    assign o_speed.speed_bps   = r_out_speed;
    assign o_speed.speed_at_ns = r_out_time;

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_dt == done_ps)
        else $error("dividers out of step");

    a_speed_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (n_speed != '0)) |-> (n_time == r_job.t_now))
        else $error("nonzero speed not stamped with sample time");

    a_cross_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !q_ge) |-> (n_time <= r_job.t_now))
        else $error("zero crossing after sample time");

endmodule

>>> rtl/trapezoid_traffic_speed_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_traffic_speed_tracker_core
// Estimates transfer speed from timestamped cumulative byte counts with the
// trapezoid rule, exact wide integer division and 48-bit saturation.
//
//   port      dir  role     fields
//   i_sample  in   sink     sample_time_ns[62:0], byte_total[47:0]
//   o_speed   out  source   speed_bps[47:0], speed_at_ns[62:0]
//
// Each sample that moves time forward passes the back end states in order:
// take the job, the split 24x31 multiply (low half, then high half), launch,
// the radix-2 dividers (one bit per step over the 79-bit product, then a
// done flag) and finish, which waits until the output register is free.
// Stale or falling samples are dropped in the cycle taken.
// Synchronous active-low reset clears the tracked state, queue and output.
// A queue of P_QUEUE_DEPTH jobs lets samples be taken while the back end
// works; the output register holds a result until the sink takes it.
// ----------------------------------------------------------------------------
module trapezoid_traffic_speed_tracker_core
    import ttst_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttst_sample_if.sink   i_sample,
    ttst_speed_if.source  o_speed
);

    logic push;
    logic full;
    logic pop;
    logic job_valid;
    t_job job_in;
    t_job job_out;

    ttst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_full   (full),
        .o_push   (push),
        .o_job    (job_in)
    );

    ttst_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    ttst_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_speed     (o_speed)
    );

endmodule
